// ----- rtl/lpdf_pkg.sv -----
package lpdf_pkg;

    localparam logic [7:0]  CHAR_LF         = 8'h0A;
    localparam logic [7:0]  CHAR_CR         = 8'h0D;
    localparam logic [3:0]  KW_LEN          = 4'd10;
    localparam logic [15:0] FRAME_LIMIT_RST = 16'd1024;

    typedef enum logic [1:0] {
        HDR_LOW     = 2'd0,
        HDR_HIGH    = 2'd1,
        HDR_PAYLOAD = 2'd2
    } t_hdr_phase;

    typedef struct packed {
        logic         binary_mode;
        logic [3:0]   kw_matched;
        logic         kw_failed;
        t_hdr_phase   phase;
        logic [7:0]   length_low;
        logic [15:0]  bytes_left;
    } t_parse_state;

    typedef struct packed {
        logic        valid;
        logic        has_data;
        logic [7:0]  data;
        logic        eom;
    } t_parse_result;

    // Characters of the keyword that switches to binary mode
    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h42;
            4'd1:    c = 8'h49;
            4'd2:    c = 8'h4E;
            4'd3:    c = 8'h41;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h59;
            4'd6:    c = 8'h4D;
            4'd7:    c = 8'h4F;
            4'd8:    c = 8'h44;
            4'd9:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/lpdf_step.sv -----
module lpdf_step
    import lpdf_pkg::*;
(
    input  t_parse_state  i_state,
    input  logic [7:0]    i_byte,
    input  logic [15:0]   i_frame_limit,
    output t_parse_state  o_state,
    output t_parse_result o_result
);

    logic [15:0] len;
    logic        last;

    assign len  = {i_byte, i_state.length_low};
    assign last = (i_state.bytes_left[15:1] == 15'd0);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (!i_state.binary_mode) begin
            priority if (i_byte == CHAR_LF) begin
                // drop line feeds
            end else if (i_byte == CHAR_CR) begin
                o_result.valid = 1'b1;
                o_result.eom   = 1'b1;
                if (!i_state.kw_failed && i_state.kw_matched == KW_LEN) begin
                    o_state.binary_mode = 1'b1;
                    o_state.phase       = HDR_LOW;
                    o_state.bytes_left  = 16'd0;
                end
                o_state.kw_matched = 4'd0;
                o_state.kw_failed  = 1'b0;
            end else begin
                if (!i_state.kw_failed && i_state.kw_matched < KW_LEN &&
                    i_byte == kw_char(i_state.kw_matched)) begin
                    o_state.kw_matched = i_state.kw_matched + 4'd1;
                end else begin
                    o_state.kw_failed = 1'b1;
                end
                o_result.valid    = 1'b1;
                o_result.has_data = 1'b1;
                o_result.data     = i_byte;
            end
        end else begin
            unique case (i_state.phase)
                HDR_HIGH: begin
                    o_state.phase = HDR_LOW;
                    if (len > i_frame_limit) begin
                        // drop oversized header, read a new one
                    end else if (len == 16'd0) begin
                        o_result.valid = 1'b1;
                        o_result.eom   = 1'b1;
                    end else begin
                        o_state.bytes_left = len;
                        o_state.phase      = HDR_PAYLOAD;
                    end
                end
                HDR_PAYLOAD: begin
                    o_result.valid    = 1'b1;
                    o_result.has_data = 1'b1;
                    o_result.data     = i_byte;
                    o_result.eom      = last;
                    if (last) begin
                        o_state.bytes_left = 16'd0;
                        o_state.phase      = HDR_LOW;
                    end else begin
                        o_state.bytes_left = i_state.bytes_left - 16'd1;
                    end
                end
                default: begin
                    o_state.length_low = i_byte;
                    o_state.phase      = HDR_HIGH;
                end
            endcase
        end
    end

endmodule

// ----- rtl/line_then_length_prefix_deframer_core.sv -----
// Line / length-prefixed deframer.
// Input channel: one received byte per word on i_rx_byte, handshake
// i_in_valid / o_in_stall. Output channel: one result word with
// o_has_data, o_payload_byte and o_end_of_message, handshake o_out_valid /
// i_out_stall. A byte that produces no result (a line feed in text mode,
// a binary header byte not ending a zero length) is consumed silently.
// The block starts in text mode: CR ends a message, LF is dropped, other
// bytes pass through. A line reading BINARYMODE switches to binary mode
// until reset; there each message is a little-endian 16-bit length plus
// that many bytes. Lengths above the frame limit (i_cfg_we / i_cfg_data,
// reset value 1024) drop the header.
// A byte sits in the input register and is parsed into the output register
// once that register is free; the result is then held there until taken.
// One byte is accepted every cycle while the receiver does not stall; the
// parse state is updated once per byte by a single level of logic.
// Reset (synchronous, active low) returns to text mode, empties both
// registers and restores the frame limit. While the receiver stalls with a
// result pending, one more byte is held in the input register and the input
// then stalls; no word is lost.
module line_then_length_prefix_deframer_core
    import lpdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_has_data,
    output logic [7:0]  o_payload_byte,
    output logic        o_end_of_message
);

    logic [15:0]   r_frame_limit;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    t_parse_state  r_state;
    t_parse_state  n_state;
    t_parse_result n_result;
    logic          r_out_valid;
    logic          r_has_data;
    logic [7:0]    r_payload_byte;
    logic          r_eom;
    logic          out_free;
    logic          advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    lpdf_step u_step (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_frame_limit (r_frame_limit),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_frame_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.valid;
        end
    end

    // load a new result only when the old one has gone
    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_has_data     <= n_result.has_data;
            r_payload_byte <= n_result.data;
            r_eom          <= n_result.eom;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_has_data       = r_has_data;
    assign o_payload_byte   = r_payload_byte;
    assign o_end_of_message = r_eom;

endmodule

// ----- rtl/lpdf_checker.sv -----
module lpdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_has_data,
    input logic [7:0]  o_payload_byte,
    input logic        o_end_of_message
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_has_data) && $stable(o_end_of_message))
        else $error("stalled result word changed");

    a_empty_is_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_end_of_message)
        else $error("result word without data is not an end marker");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_payload_byte == 8'h00)
        else $error("result word without data carries a byte");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind line_then_length_prefix_deframer_core lpdf_checker u_lpdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_has_data       (o_has_data),
    .o_payload_byte   (o_payload_byte),
    .o_end_of_message (o_end_of_message)
);
